// ===== hdl/mexp_pkg.sv =====
// mexp_pkg: shared types for the modular exponentiation core
// controller state encoding, datapath command and status bundles, config indexes
// no dependencies
package mexp_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_SQR_LOAD,
    ST_SQR,
    ST_MUL_LOAD,
    ST_MUL,
    ST_NEXT,
    ST_FINISH
  } mexp_state_t;

  typedef struct packed {
    logic load;
    logic red_step;
    logic set_zero;
    logic init_acc;
    logic mul_start;
    logic mul_sel_base;
    logic mul_step;
    logic mul_last;
    logic exp_shift;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic base_zero;
    logic exp_msb;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hdl/mexp_in_if.sv =====
// mexp_in_if: input channel carrying one message word per beat
// depends on nothing
interface mexp_in_if #(
  parameter int W = 32
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] message;

  modport source (output valid, output message, input ready);
  modport sink   (input valid, input message, output ready);
endinterface

// ===== hdl/mexp_out_if.sv =====
// mexp_out_if: result channel carrying one result word per beat
// depends on nothing
interface mexp_out_if #(
  parameter int W = 32
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

// ===== hdl/modular_exponentiation_core.sv =====
// modular_exponentiation_core: top level of the modular exponentiation block
// depends on mexp_pkg, mexp_in_if, mexp_out_if, mexp_ctrl, mexp_datapath
//
// usage: write modulus (index 0) and exponent (index 1) on the cfg port while
// the block is idle; a modulus write of zero stores one. each beat on in_if
// carries one message word; the block returns message^exponent mod modulus as
// one beat on out_if. a zero reduced message gives zero, else a zero exponent
// gives one.
// operation: one item at a time, in_if.ready is high only while idle. the message
// is reduced one bit per cycle, then each exponent bit costs one modular
// square and, for a set bit, one modular multiply, on the single shared
// bit-serial multiplier. a zero reduced message skips the exponent scan and
// goes straight to the result. once the result is moved into the output
// register the block is idle again and can accept the next beat.
// the result sits in an output register, so a stalled receiver only holds the
// block once the next result is ready. reset (rst_n low, synchronous) sets
// modulus to 1 and exponent to 0 and drops any item in flight.
module modular_exponentiation_core import mexp_pkg::*; #(
  parameter int MODULUS_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  mexp_in_if.sink                  in_if,
  mexp_out_if.source               out_if,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [MODULUS_WIDTH-1:0] cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mexp_ctrl #(
    .W (MODULUS_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .status   (status),
    .cmd      (cmd)
  );

  mexp_datapath #(
    .W (MODULUS_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .message   (in_if.message),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .result    (out_if.result)
  );

endmodule

// ===== hdl/mexp_datapath.sv =====
// mexp_datapath: key registers, bit-serial reduction, shared modular multiplier,
// exponent shifter and output register; driven by commands from mexp_ctrl
// depends on mexp_pkg
module mexp_datapath import mexp_pkg::*; #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [W-1:0]         cfg_wdata,
  input  logic [W-1:0]         message,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [W-1:0]         result
);

  logic [W-1:0] n_r;
  logic [W-1:0] e_r;
  logic [W-1:0] msg_sh_r;
  logic [W-1:0] rem_r;
  logic [W-1:0] acc_r;
  logic [W-1:0] prod_r;
  logic [W-1:0] mop_r;
  logic         sel_r;
  logic [W-1:0] exp_sh_r;
  logic [W-1:0] result_r;
  logic         out_valid_r;

  logic [W:0]   n_ext;
  logic [W:0]   red_ext;
  logic [W-1:0] rem_step;
  logic [W-1:0] op_a;
  logic [W:0]   dbl;
  logic [W-1:0] dbl_red;
  logic [W:0]   sum;
  logic [W-1:0] sum_red;
  logic [W-1:0] prod_step;

  // one restoring remainder step per cycle
  always_comb begin
    n_ext   = {1'b0, n_r};
    red_ext = {rem_r, msg_sh_r[W-1]};
    if (red_ext >= n_ext) begin
      rem_step = W'(red_ext - n_ext);
    end else begin
      rem_step = red_ext[W-1:0];
    end
  end

  // one shift-and-add step of a mod n, multiplier bit from the top
  always_comb begin
    op_a = sel_r ? rem_r : acc_r;
    dbl  = {prod_r, 1'b0};
    if (dbl >= n_ext) begin
      dbl_red = W'(dbl - n_ext);
    end else begin
      dbl_red = dbl[W-1:0];
    end
    sum = {1'b0, dbl_red} + {1'b0, op_a};
    if (sum >= n_ext) begin
      sum_red = W'(sum - n_ext);
    end else begin
      sum_red = sum[W-1:0];
    end
    prod_step = mop_r[W-1] ? sum_red : dbl_red;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= W'(1);
      e_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_MODULUS) begin
        n_r <= (cfg_wdata == '0) ? W'(1) : cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_EXPONENT) begin
        e_r <= cfg_wdata;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      msg_sh_r <= message;
      rem_r    <= '0;
    end else if (cmd.red_step) begin
      msg_sh_r <= {msg_sh_r[W-2:0], 1'b0};
      rem_r    <= rem_step;
    end
    if (cmd.set_zero) begin
      acc_r <= '0;
    end else if (cmd.init_acc) begin
      acc_r <= W'(1);
    end else if (cmd.mul_step && cmd.mul_last) begin
      acc_r <= prod_step;
    end
    if (cmd.init_acc) begin
      exp_sh_r <= e_r;
    end else if (cmd.exp_shift) begin
      exp_sh_r <= {exp_sh_r[W-2:0], 1'b0};
    end
    if (cmd.mul_start) begin
      prod_r <= '0;
      mop_r  <= acc_r;
      sel_r  <= cmd.mul_sel_base;
    end else if (cmd.mul_step) begin
      prod_r <= prod_step;
      mop_r  <= {mop_r[W-2:0], 1'b0};
    end
    if (cmd.emit) begin
      result_r <= acc_r;
    end
  end

  assign status.base_zero = (rem_r == '0);
  assign status.exp_msb   = exp_sh_r[W-1];
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign result    = result_r;

  a_rem_below_n : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.red_step |-> rem_r < n_r)
    else $error("remainder not reduced");

  a_mul_operands_reduced : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_step |-> (prod_r < n_r) && (acc_r < n_r) && (op_a < n_r))
    else $error("multiplier operand not reduced");

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_valid_r || out_ready)
    else $error("result overwritten before taken");

endmodule

// ===== hdl/mexp_ctrl.sv =====
// mexp_ctrl: sequencer for reduce, square-and-multiply and result hand-off
// depends on mexp_pkg; drives mexp_datapath through dp_cmd_t
module mexp_ctrl import mexp_pkg::*; #(
  parameter int W = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam int CNT_W = $clog2(W);

  mexp_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] bit_r, bit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      bit_r   <= bit_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    bit_nxt   = bit_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = CNT_W'(W - 1);
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd.red_step = 1'b1;
        cnt_nxt      = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.base_zero) begin
          cmd.set_zero = 1'b1;
          state_nxt    = ST_FINISH;
        end else begin
          cmd.init_acc = 1'b1;
          bit_nxt      = CNT_W'(W - 1);
          state_nxt    = ST_SQR_LOAD;
        end
      end
      ST_SQR_LOAD: begin
        cmd.mul_start = 1'b1;
        cnt_nxt       = CNT_W'(W - 1);
        state_nxt     = ST_SQR;
      end
      ST_SQR: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          cmd.mul_last = 1'b1;
          state_nxt    = status.exp_msb ? ST_MUL_LOAD : ST_NEXT;
        end
      end
      ST_MUL_LOAD: begin
        cmd.mul_start    = 1'b1;
        cmd.mul_sel_base = 1'b1;
        cnt_nxt          = CNT_W'(W - 1);
        state_nxt        = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          cmd.mul_last = 1'b1;
          state_nxt    = ST_NEXT;
        end
      end
      ST_NEXT: begin
        cmd.exp_shift = 1'b1;
        bit_nxt       = bit_r - CNT_W'(1);
        state_nxt     = (bit_r == '0) ? ST_FINISH : ST_SQR_LOAD;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_accept_starts_reduce : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_REDUCE)
    else $error("accepted beat did not start reduction");

  a_last_bit_finishes : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_NEXT && bit_r == '0 |=> state_r == ST_FINISH)
    else $error("exponent scan overran");

  a_emit_frees_input : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> in_ready)
    else $error("input not reopened after result");

endmodule
